// ===== rtl/stepper_stage_sequencer_macros.svh =====
// Assertion macros shared by the checker.
`ifndef STEPPER_STAGE_SEQUENCER_MACROS_SVH
`define STEPPER_STAGE_SEQUENCER_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define SSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define SSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/sss_pkg.sv =====
package sss_pkg;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_ERASE = 3'd2,
        ACT_RUN   = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_SEEK  = 3'd1,
        MODE_PAUSE = 3'd2,
        MODE_BACK  = 3'd3,
        MODE_FETCH = 3'd4,
        MODE_MOVE  = 3'd5,
        MODE_DWELL = 3'd6
    } mode_t;

    typedef enum logic [0:0] {
        PH_IDLE = 1'b0,
        PH_EXEC = 1'b1
    } phase_t;

    localparam logic [1:0] CFG_FAST  = 2'd0;
    localparam logic [1:0] CFG_SLOW  = 2'd1;
    localparam logic [1:0] CFG_PAUSE = 2'd2;

    localparam logic [13:0] FAST_RESET  = 14'd50;
    localparam logic [13:0] SLOW_RESET  = 14'd100;
    localparam logic [13:0] PAUSE_RESET = 14'd100;

    typedef struct packed {
        logic [2:0]  action;
        logic        limit_switch;
        logic [7:0]  stage_index;
        logic [13:0] target_position;
        logic [13:0] step_half_period;
        logic [2:0]  aux_select;
        logic [13:0] dwell_time;
        logic [7:0]  next_stage;
    } in_req_t;

    typedef struct packed {
        logic        step_out;
        logic        direction_out;
        logic        driver_enable;
        logic [5:0]  aux_out;
        logic [7:0]  stage_now;
        logic [2:0]  mode_code;
        logic signed [15:0] position_now;
        logic        fault;
    } out_req_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic        do_tick;
        logic        do_run;
        logic        do_stop;
        logic        do_store;
        logic        store_valid;
        logic        edge_rise;
        logic        limit_switch;
        logic [7:0]  stage_index;
        logic [13:0] target_position;
        logic [13:0] step_half_period;
        logic [2:0]  aux_select;
        logic [13:0] dwell_time;
        logic [7:0]  next_stage;
    } cmd_t;

    // Stage record: target, half, aux, dwell, next.
    typedef struct packed {
        logic [13:0] target;
        logic [13:0] half;
        logic [2:0]  aux;
        logic [13:0] dwell;
        logic [7:0]  next;
    } rec_t;

endpackage

// ===== rtl/sss_ram.sv =====
module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/sss_front.sv =====
module sss_front #(
    parameter int STAGE_DEPTH = 256,
    parameter int TIME_MAX    = 9999,
    parameter int POS_MAX     = 9999
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  sss_pkg::in_req_t  in_data,
    output logic              cmd_valid,
    input  logic              cmd_stall,
    output sss_pkg::cmd_t     cmd
);

    logic         switch_last_reg;
    logic         switch_last_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    sss_pkg::cmd_t q_reg [2];
    sss_pkg::cmd_t q_next [2];
    sss_pkg::cmd_t fresh;
    logic         push;
    logic         pop;
    logic         idx_ok;
    logic         wr_ok;

    // The mode-dependent part of the write filter is applied in the back part,
    // so the front only checks the fields of the request itself.
    assign idx_ok = (in_data.stage_index != 8'd0)
                    && ({24'd0, in_data.stage_index} < STAGE_DEPTH);
    assign wr_ok = idx_ok
                   && ({18'd0, in_data.target_position} <= POS_MAX)
                   && (in_data.step_half_period != 14'd0)
                   && ({18'd0, in_data.step_half_period} <= TIME_MAX)
                   && (in_data.aux_select <= 3'd5)
                   && (in_data.dwell_time != 14'd0)
                   && ({18'd0, in_data.dwell_time} <= TIME_MAX)
                   && (in_data.next_stage != 8'd0);

    always_comb
    begin
        fresh = '0;
        fresh.do_tick = (in_data.action == sss_pkg::ACT_TICK);
        fresh.do_run = (in_data.action == sss_pkg::ACT_RUN);
        fresh.do_stop = (in_data.action == sss_pkg::ACT_STOP);
        fresh.do_store = ((in_data.action == sss_pkg::ACT_WRITE) && wr_ok)
                         || ((in_data.action == sss_pkg::ACT_ERASE) && idx_ok);
        fresh.store_valid = (in_data.action == sss_pkg::ACT_WRITE);
        fresh.edge_rise = in_data.limit_switch && !switch_last_reg;
        fresh.limit_switch = in_data.limit_switch;
        fresh.stage_index = in_data.stage_index;
        fresh.target_position = in_data.target_position;
        fresh.step_half_period = in_data.step_half_period;
        fresh.aux_select = in_data.aux_select;
        fresh.dwell_time = in_data.dwell_time;
        fresh.next_stage = in_data.next_stage;
    end

    assign stall = (count_reg == 2'd2);
    assign push = valid && !stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop = cmd_valid && !cmd_stall;
    assign cmd = q_reg[0];

    always_comb
    begin
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        count_next = count_reg;
        switch_last_next = switch_last_reg;
        if (push)
        begin
            switch_last_next = in_data.limit_switch;
        end
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (push)
        begin
            if (pop)
            begin
                if (count_reg == 2'd1)
                begin
                    q_next[0] = fresh;
                end
                else
                begin
                    q_next[1] = fresh;
                end
            end
            else if (count_reg == 2'd0)
            begin
                q_next[0] = fresh;
            end
            else
            begin
                q_next[1] = fresh;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            switch_last_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            switch_last_reg <= switch_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end

endmodule

// ===== rtl/sss_back.sv =====
module sss_back #(
    parameter int STAGE_DEPTH = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  sss_pkg::cmd_t     cmd,
    input  logic [13:0]       fast_half,
    input  logic [13:0]       slow_half,
    input  logic [13:0]       pause_len,
    output logic              valid,
    input  logic              stall,
    output sss_pkg::out_req_t out_data
);

    localparam int AW = $clog2(STAGE_DEPTH);

    sss_pkg::mode_t mode_reg, mode_next;
    logic [7:0]   stage_reg, stage_next;
    logic [15:0]  goal_reg, goal_next;
    logic [15:0]  axis_reg, axis_next;
    logic [13:0]  tick_reg, tick_next;
    logic         phase_pulse_reg, phase_pulse_next;
    logic         dir_reg, dir_next;
    logic         fault_reg, fault_next;
    logic [5:0]   aux_reg, aux_next;
    sss_pkg::rec_t act_reg, act_next;
    logic [STAGE_DEPTH-1:0] vld_reg, vld_next;
    sss_pkg::phase_t ph_reg, ph_next;
    sss_pkg::cmd_t hold_reg;
    logic         out_valid_reg, out_valid_next;
    sss_pkg::out_req_t out_reg, out_next;

    sss_pkg::rec_t rd_rec;
    sss_pkg::rec_t wr_rec;
    logic          take;
    logic          finish;
    logic [AW-1:0] raddr;
    logic [13:0]   tick_inc;
    logic [13:0]   half_eff;
    logic          half_hit;
    logic          rec_ok;
    logic [15:0]   axis_step;
    logic          sw;

    assign wr_rec = '{target: cmd.target_position, half: cmd.step_half_period,
                      aux: cmd.aux_select, dwell: cmd.dwell_time, next: cmd.next_stage};
    assign raddr = stage_reg[AW-1:0];

    sss_ram #(.WIDTH($bits(sss_pkg::rec_t)), .DEPTH(STAGE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (take && cmd.do_store && cmd.store_valid && (mode_reg == sss_pkg::MODE_OFF)),
        .waddr (cmd.stage_index[AW-1:0]),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (rd_rec)
    );

    // Each request first reads the stage store, then executes.
    assign cmd_stall = (ph_reg != sss_pkg::PH_IDLE);
    assign take = cmd_valid && !cmd_stall;
    assign finish = (ph_reg == sss_pkg::PH_EXEC) && !(out_valid_reg && stall);
    assign valid = out_valid_reg;
    assign out_data = out_reg;

    always_comb
    begin
        ph_next = ph_reg;
        case (ph_reg)
            sss_pkg::PH_IDLE:
            begin
                if (take)
                begin
                    ph_next = sss_pkg::PH_EXEC;
                end
            end
            sss_pkg::PH_EXEC:
            begin
                if (finish)
                begin
                    ph_next = sss_pkg::PH_IDLE;
                end
            end
            default:
            begin
                ph_next = sss_pkg::PH_IDLE;
            end
        endcase
    end

    assign tick_inc = tick_reg + 14'd1;
    assign sw = hold_reg.limit_switch;
    assign rec_ok = ({24'd0, stage_reg} < STAGE_DEPTH) && vld_reg[raddr];

    always_comb
    begin
        half_eff = 14'd1;
        case (mode_reg)
            sss_pkg::MODE_SEEK:
            begin
                half_eff = fast_half;
            end
            sss_pkg::MODE_BACK:
            begin
                half_eff = slow_half;
            end
            default:
            begin
                half_eff = act_reg.half;
            end
        endcase
        if (half_eff == 14'd0)
        begin
            half_eff = 14'd1;
        end
    end

    assign half_hit = (tick_inc >= half_eff);

    always_comb
    begin
        mode_next = mode_reg;
        stage_next = stage_reg;
        goal_next = goal_reg;
        axis_next = axis_reg;
        tick_next = tick_reg;
        phase_pulse_next = phase_pulse_reg;
        dir_next = dir_reg;
        fault_next = fault_reg;
        aux_next = aux_reg;
        act_next = act_reg;
        vld_next = vld_reg;
        axis_step = 16'd0;
        if (finish)
        begin
            if (hold_reg.edge_rise)
            begin
                axis_next = 16'd0;
                goal_next = 16'd0;
            end
            if (hold_reg.do_store && (mode_reg == sss_pkg::MODE_OFF))
            begin
                vld_next[hold_reg.stage_index[AW-1:0]] = hold_reg.store_valid;
            end
            if (hold_reg.do_stop)
            begin
                mode_next = sss_pkg::MODE_OFF;
                stage_next = 8'd0;
                tick_next = 14'd0;
                phase_pulse_next = 1'b0;
                dir_next = 1'b0;
                aux_next = 6'd0;
            end
            else if (hold_reg.do_run && (mode_reg == sss_pkg::MODE_OFF))
            begin
                fault_next = 1'b0;
                stage_next = 8'd0;
                aux_next = 6'd0;
                dir_next = 1'b0;
                tick_next = 14'd0;
                if (goal_next == 16'd0)
                begin
                    phase_pulse_next = 1'b0;
                    if (pause_len == 14'd0)
                    begin
                        dir_next = 1'b1;
                        if (!sw)
                        begin
                            stage_next = 8'd1;
                            mode_next = sss_pkg::MODE_FETCH;
                        end
                        else
                        begin
                            mode_next = sss_pkg::MODE_BACK;
                            phase_pulse_next = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next = sss_pkg::MODE_PAUSE;
                    end
                end
                else
                begin
                    mode_next = sss_pkg::MODE_SEEK;
                    phase_pulse_next = 1'b1;
                end
            end
            else if (hold_reg.do_tick)
            begin
                case (mode_reg)
                    sss_pkg::MODE_SEEK:
                    begin
                        tick_next = half_hit ? 14'd0 : tick_inc;
                        if (half_hit)
                        begin
                            if (phase_pulse_reg)
                            begin
                                phase_pulse_next = 1'b0;
                            end
                            else if (goal_next == 16'd0)
                            begin
                                phase_pulse_next = 1'b0;
                                if (pause_len == 14'd0)
                                begin
                                    dir_next = 1'b1;
                                    if (!sw)
                                    begin
                                        stage_next = 8'd1;
                                        mode_next = sss_pkg::MODE_FETCH;
                                    end
                                    else
                                    begin
                                        mode_next = sss_pkg::MODE_BACK;
                                        phase_pulse_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    mode_next = sss_pkg::MODE_PAUSE;
                                end
                            end
                            else
                            begin
                                phase_pulse_next = 1'b1;
                            end
                        end
                    end
                    sss_pkg::MODE_PAUSE:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= pause_len)
                        begin
                            tick_next = 14'd0;
                            dir_next = 1'b1;
                            if (!sw)
                            begin
                                stage_next = 8'd1;
                                mode_next = sss_pkg::MODE_FETCH;
                                phase_pulse_next = 1'b0;
                            end
                            else
                            begin
                                mode_next = sss_pkg::MODE_BACK;
                                phase_pulse_next = 1'b1;
                            end
                        end
                    end
                    sss_pkg::MODE_BACK:
                    begin
                        tick_next = half_hit ? 14'd0 : tick_inc;
                        if (half_hit)
                        begin
                            if (phase_pulse_reg)
                            begin
                                phase_pulse_next = 1'b0;
                            end
                            else if (!sw)
                            begin
                                stage_next = 8'd1;
                                mode_next = sss_pkg::MODE_FETCH;
                            end
                            else
                            begin
                                phase_pulse_next = 1'b1;
                            end
                        end
                    end
                    sss_pkg::MODE_FETCH:
                    begin
                        if (!rec_ok)
                        begin
                            fault_next = 1'b1;
                            mode_next = sss_pkg::MODE_OFF;
                            stage_next = 8'd0;
                            tick_next = 14'd0;
                            phase_pulse_next = 1'b0;
                            dir_next = 1'b0;
                            aux_next = 6'd0;
                        end
                        else
                        begin
                            act_next = rd_rec;
                            goal_next = {2'b00, rd_rec.target};
                            tick_next = 14'd0;
                            if (goal_next == axis_next)
                            begin
                                mode_next = sss_pkg::MODE_DWELL;
                                phase_pulse_next = 1'b0;
                                aux_next = aux_reg | (6'd1 << rd_rec.aux);
                            end
                            else
                            begin
                                dir_next = (goal_next > axis_next);
                                mode_next = sss_pkg::MODE_MOVE;
                                phase_pulse_next = 1'b1;
                            end
                        end
                    end
                    sss_pkg::MODE_MOVE:
                    begin
                        tick_next = half_hit ? 14'd0 : tick_inc;
                        if (half_hit)
                        begin
                            if (phase_pulse_reg)
                            begin
                                phase_pulse_next = 1'b0;
                            end
                            else
                            begin
                                axis_step = dir_reg ? (axis_next + 16'd1)
                                                    : (axis_next - 16'd1);
                                axis_next = axis_step;
                                if (axis_step == goal_next)
                                begin
                                    mode_next = sss_pkg::MODE_DWELL;
                                    tick_next = 14'd0;
                                    aux_next = aux_reg | (6'd1 << act_reg.aux);
                                end
                                else
                                begin
                                    phase_pulse_next = 1'b1;
                                end
                            end
                        end
                    end
                    sss_pkg::MODE_DWELL:
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= act_reg.dwell)
                        begin
                            aux_next = 6'd0;
                            stage_next = act_reg.next;
                            mode_next = sss_pkg::MODE_FETCH;
                            tick_next = 14'd0;
                            phase_pulse_next = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_next = out_reg;
        out_valid_next = out_valid_reg && stall;
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_next.step_out = (mode_next != sss_pkg::MODE_OFF) && phase_pulse_next;
            out_next.direction_out = (mode_next != sss_pkg::MODE_OFF) && dir_next;
            out_next.driver_enable = (mode_next != sss_pkg::MODE_OFF);
            out_next.aux_out = aux_next;
            out_next.stage_now = (mode_next != sss_pkg::MODE_OFF) ? stage_next : 8'd0;
            out_next.mode_code = mode_next;
            out_next.position_now = $signed(axis_next);
            out_next.fault = fault_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= sss_pkg::MODE_OFF;
            stage_reg <= 8'd0;
            goal_reg <= 16'hFFFF;
            axis_reg <= 16'd0;
            tick_reg <= 14'd0;
            phase_pulse_reg <= 1'b0;
            dir_reg <= 1'b0;
            fault_reg <= 1'b0;
            aux_reg <= 6'd0;
            act_reg <= '0;
            vld_reg <= '0;
            ph_reg <= sss_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            stage_reg <= stage_next;
            goal_reg <= goal_next;
            axis_reg <= axis_next;
            tick_reg <= tick_next;
            phase_pulse_reg <= phase_pulse_next;
            dir_reg <= dir_next;
            fault_reg <= fault_next;
            aux_reg <= aux_next;
            act_reg <= act_next;
            vld_reg <= vld_next;
            ph_reg <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= cmd;
        end
        out_reg <= out_next;
    end

endmodule

// ===== rtl/stepper_stage_sequencer.sv =====
// Single-axis stepper program runner. Each input request (tick, stage write or
// erase, run, stop) yields exactly one status request. A classifying front part
// feeds a two-entry queue; the back part handles one request at a time, first
// reading the stage store (a registered RAM) and then executing and registering
// the status, and takes no new request until the last one is done; the execute
// step holds while the output is stalled. Stage valid marks are flip-flops
// cleared by reset, so no clearing pass is needed.
module stepper_stage_sequencer #(
    parameter int STAGE_DEPTH = 256,
    parameter int TIME_MAX    = 9999,
    parameter int POS_MAX     = 9999
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  sss_pkg::in_req_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output sss_pkg::out_req_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [13:0]       cfg_data
);

    logic          cmd_valid;
    logic          cmd_stall;
    sss_pkg::cmd_t cmd;
    logic [13:0]   fast_reg;
    logic [13:0]   slow_reg;
    logic [13:0]   pause_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= sss_pkg::FAST_RESET;
            slow_reg <= sss_pkg::SLOW_RESET;
            pause_reg <= sss_pkg::PAUSE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sss_pkg::CFG_FAST:
                begin
                    fast_reg <= cfg_data;
                end
                sss_pkg::CFG_SLOW:
                begin
                    slow_reg <= cfg_data;
                end
                sss_pkg::CFG_PAUSE:
                begin
                    pause_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    sss_front #(.STAGE_DEPTH(STAGE_DEPTH), .TIME_MAX(TIME_MAX), .POS_MAX(POS_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd)
    );

    sss_back #(.STAGE_DEPTH(STAGE_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .fast_half (fast_reg),
        .slow_half (slow_reg),
        .pause_len (pause_reg),
        .valid     (out_valid),
        .stall     (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/sss_checker.sv =====
`include "stepper_stage_sequencer_macros.svh"

module sss_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input sss_pkg::out_req_t out_data
);

    `SSS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid)
    `SSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                     out_valid && $stable(out_data))
    `SSS_ASSERT_IMPL(a_off_quiet, clk, rst_n,
                     out_valid && (out_data.mode_code == sss_pkg::MODE_OFF),
                     !out_data.step_out && !out_data.driver_enable
                     && (out_data.stage_now == 8'd0))
    `SSS_ASSERT_IMPL(a_on_enabled, clk, rst_n,
                     out_valid && (out_data.mode_code != sss_pkg::MODE_OFF),
                     out_data.driver_enable && !out_data.fault)
    `SSS_ASSERT_IMPL(a_mode_range, clk, rst_n, out_valid, out_data.mode_code != 3'd7)

endmodule

bind stepper_stage_sequencer sss_checker u_sss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/stepper_stage_sequencer_tb.sv =====
module stepper_stage_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 256;
    localparam int TMAX     = 9999;
    localparam int PMAX     = 9999;
    localparam int AUX_LAST = 5;
    localparam int SETTLE   = 12;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    sss_pkg::in_req_t   in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    sss_pkg::out_req_t  out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_data = '0;

    stepper_stage_sequencer u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    sss_pkg::in_req_t  pending_cmds[$];
    sss_pkg::out_req_t status_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_seen = 0;
    int n_faults = 0;
    int n_dwells = 0;
    bit quiet = 1'b0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;

    // Mirror of the block's state.
    logic [13:0] fast_hp, slow_hp, pause_len;
    logic        st_valid [DEPTH];
    sss_pkg::rec_t st_rec [DEPTH];
    sss_pkg::rec_t cur;
    sss_pkg::mode_t mode_r;
    logic [7:0]  stage_r;
    logic [15:0] goal_r, axis_r, ticks_r;
    logic        phase_r, sw_last, dir_r, fault_r;
    logic [5:0]  aux_r;

    function void go_off();
        mode_r = sss_pkg::MODE_OFF;
        stage_r = '0;
        ticks_r = '0;
        phase_r = 1'b0;
        dir_r = 1'b0;
        aux_r = '0;
    endfunction

    function void start_pulse(sss_pkg::mode_t m);
        mode_r = m;
        ticks_r = '0;
        phase_r = 1'b1;
    endfunction

    function void enter_fetch();
        mode_r = sss_pkg::MODE_FETCH;
        ticks_r = '0;
        phase_r = 1'b0;
    endfunction

    function void enter_backoff(logic sw);
        dir_r = 1'b1;
        if (!sw)
        begin
            stage_r = 8'd1;
            enter_fetch();
        end
        else
            start_pulse(sss_pkg::MODE_BACK);
    endfunction

    function void enter_pause(logic sw);
        ticks_r = '0;
        phase_r = 1'b0;
        if (pause_len == 0)
            enter_backoff(sw);
        else
            mode_r = sss_pkg::MODE_PAUSE;
    endfunction

    function void enter_dwell();
        mode_r = sss_pkg::MODE_DWELL;
        ticks_r = '0;
        phase_r = 1'b0;
        aux_r = aux_r | 6'(1 << (cur.aux % 6));
        n_dwells++;
    endfunction

    function void enter_moving();
        if (goal_r == axis_r)
            enter_dwell();
        else
        begin
            dir_r = goal_r > axis_r;
            start_pulse(sss_pkg::MODE_MOVE);
        end
    endfunction

    function automatic bit half_elapsed(logic [13:0] hp);
        logic [15:0] h;
        h = (hp == 0) ? 16'd1 : {2'b00, hp};
        ticks_r = ticks_r + 16'd1;
        if (ticks_r < h)
            return 1'b0;
        ticks_r = '0;
        return 1'b1;
    endfunction

    function void run_tick(logic sw);
        case (mode_r)
            sss_pkg::MODE_SEEK:
                if (half_elapsed(fast_hp))
                begin
                    if (phase_r) phase_r = 1'b0;
                    else if (goal_r == 0) enter_pause(sw);
                    else phase_r = 1'b1;
                end
            sss_pkg::MODE_PAUSE:
            begin
                ticks_r = ticks_r + 16'd1;
                if (ticks_r >= {2'b00, pause_len}) enter_backoff(sw);
            end
            sss_pkg::MODE_BACK:
                if (half_elapsed(slow_hp))
                begin
                    if (phase_r) phase_r = 1'b0;
                    else if (!sw)
                    begin
                        stage_r = 8'd1;
                        enter_fetch();
                    end
                    else phase_r = 1'b1;
                end
            sss_pkg::MODE_FETCH:
                if (!st_valid[stage_r])
                begin
                    fault_r = 1'b1;
                    n_faults++;
                    go_off();
                end
                else
                begin
                    cur = st_rec[stage_r];
                    goal_r = {2'b00, cur.target};
                    enter_moving();
                end
            sss_pkg::MODE_MOVE:
                if (half_elapsed(cur.half))
                begin
                    if (phase_r) phase_r = 1'b0;
                    else
                    begin
                        axis_r = dir_r ? axis_r + 16'd1 : axis_r - 16'd1;
                        if (axis_r == goal_r) enter_dwell();
                        else phase_r = 1'b1;
                    end
                end
            sss_pkg::MODE_DWELL:
            begin
                ticks_r = ticks_r + 16'd1;
                if (ticks_r >= {2'b00, cur.dwell})
                begin
                    aux_r = '0;
                    stage_r = cur.next;
                    enter_fetch();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic sss_pkg::out_req_t next_status(sss_pkg::in_req_t r);
        sss_pkg::out_req_t o;
        bit on;
        if (r.limit_switch && !sw_last)
        begin
            axis_r = '0;
            goal_r = '0;
        end
        sw_last = r.limit_switch;
        case (r.action)
            sss_pkg::ACT_TICK: run_tick(r.limit_switch);
            sss_pkg::ACT_WRITE:
                if (mode_r == sss_pkg::MODE_OFF && r.stage_index != 0
                    && r.target_position <= PMAX
                    && r.step_half_period != 0 && r.step_half_period <= TMAX
                    && r.aux_select <= AUX_LAST && r.dwell_time != 0
                    && r.dwell_time <= TMAX && r.next_stage != 0)
                begin
                    st_valid[r.stage_index] = 1'b1;
                    st_rec[r.stage_index] = '{r.target_position, r.step_half_period,
                                              r.aux_select, r.dwell_time, r.next_stage};
                end
            sss_pkg::ACT_ERASE:
                if (mode_r == sss_pkg::MODE_OFF && r.stage_index != 0)
                begin
                    st_valid[r.stage_index] = 1'b0;
                    st_rec[r.stage_index] = '0;
                end
            sss_pkg::ACT_RUN:
                if (mode_r == sss_pkg::MODE_OFF)
                begin
                    fault_r = 1'b0;
                    stage_r = '0;
                    aux_r = '0;
                    dir_r = 1'b0;
                    if (goal_r == 0) enter_pause(r.limit_switch);
                    else start_pulse(sss_pkg::MODE_SEEK);
                end
            sss_pkg::ACT_STOP: go_off();
            default: ;
        endcase
        on = mode_r != sss_pkg::MODE_OFF;
        o.step_out = on && phase_r;
        o.direction_out = on && dir_r;
        o.driver_enable = on;
        o.aux_out = aux_r;
        o.stage_now = on ? stage_r : 8'd0;
        o.mode_code = mode_r;
        o.position_now = axis_r;
        o.fault = fault_r;
        return o;
    endfunction

    // Request driver: predicts each status as its request is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                status_q.push_back(next_status(in_data));
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 26))
                begin
                    in_data <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Status monitor and output backpressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_seen++;
                if (status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected status %0h", $time, out_data);
                end
                else
                begin
                    sss_pkg::out_req_t w;
                    w = status_q.pop_front();
                    check_field("step_out", w.step_out, out_data.step_out);
                    check_field("direction_out", w.direction_out, out_data.direction_out);
                    check_field("driver_enable", w.driver_enable, out_data.driver_enable);
                    check_field("aux_out", w.aux_out, out_data.aux_out);
                    check_field("stage_now", w.stage_now, out_data.stage_now);
                    check_field("mode_code", w.mode_code, out_data.mode_code);
                    check_field("position_now", w.position_now, out_data.position_now);
                    check_field("fault", w.fault, out_data.fault);
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_req != hold_done)
            begin
                hold_done <= hold_req;
                hold_left <= 150;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 26);
        end
    end

    function automatic sss_pkg::in_req_t mk(sss_pkg::action_t a, logic sw, int idx, int tgt,
                                            int hp, int ax, int dw, int nx);
        sss_pkg::in_req_t r;
        r.action = a;
        r.limit_switch = sw;
        r.stage_index = 8'(idx);
        r.target_position = 14'(tgt);
        r.step_half_period = 14'(hp);
        r.aux_select = 3'(ax);
        r.dwell_time = 14'(dw);
        r.next_stage = 8'(nx);
        return r;
    endfunction

    function automatic sss_pkg::in_req_t noise();
        sss_pkg::in_req_t r;
        r = sss_pkg::in_req_t'({$urandom, $urandom, $urandom});
        return r;
    endfunction

    task automatic add_tick(logic sw);
        pending_cmds.push_back(mk(sss_pkg::ACT_TICK, sw, 0, 0, 0, 0, 0, 0));
    endtask

    // One stage program: write a short chain, maybe erase a stage or add noise, run, home, execute on ticks and stop.
    task automatic add_program();
        int n, seek, high, rest, nx;
        n = $urandom_range(1, 4);
        for (int i = 1; i <= n; i++)
        begin
            nx = i + 1;
            if (i == n)
                case ($urandom_range(2))
                    0: nx = 1;
                    1: nx = n + 1;
                    default: nx = $urandom_range(1, 255);
                endcase
            pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, i, $urandom_range(15),
                                      $urandom_range(1, 3), $urandom_range(AUX_LAST),
                                      $urandom_range(1, 4), nx));
        end
        if ($urandom_range(3) == 0)
            pending_cmds.push_back(mk(sss_pkg::ACT_ERASE, 1'b0, $urandom_range(1, n),
                                      0, 0, 0, 0, 0));
        if ($urandom_range(5) == 0)
            pending_cmds.push_back(noise());
        pending_cmds.push_back(mk(sss_pkg::ACT_RUN, 1'b0, 0, 0, 0, 0, 0, 0));
        seek = $urandom_range(12);
        high = $urandom_range(6);
        rest = $urandom_range(10, 36);
        repeat (seek) add_tick(1'b0);
        repeat (high) add_tick(1'b1);
        for (int k = 0; k < rest; k++)
        begin
            if ($urandom_range(40) == 0)
                pending_cmds.push_back(noise());
            add_tick($urandom_range(60) == 0);
        end
        pending_cmds.push_back(mk(sss_pkg::ACT_STOP, 1'b0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || in_valid || status_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [13:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            sss_pkg::CFG_FAST: fast_hp = val;
            sss_pkg::CFG_SLOW: slow_hp = val;
            sss_pkg::CFG_PAUSE: pause_len = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [13:0] settings [6][3];
        settings = '{'{1, 1, 0}, '{2, 3, 1}, '{1, 2, 4}, '{3, 1, 2},
                     '{9999, 9999, 9999}, '{1, 1, 9999}};
        fast_hp = sss_pkg::FAST_RESET;
        slow_hp = sss_pkg::SLOW_RESET;
        pause_len = sss_pkg::PAUSE_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            st_valid[i] = 1'b0;
            st_rec[i] = '0;
        end
        cur = '0;
        goal_r = 16'hFFFF;
        axis_r = '0;
        sw_last = 1'b0;
        fault_r = 1'b0;
        go_off();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 255, 9999, 9999, 5, 9999, 255));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 0, 1, 1, 0, 1, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 10000, 1, 0, 1, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 16383, 16383, 7, 16383, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 1, 0, 0, 1, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 1, 1, 6, 1, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 1, 1, 0, 0, 1));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 2, 1, 1, 0, 1, 0));
        pending_cmds.push_back(mk(sss_pkg::ACT_ERASE, 1'b0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(sss_pkg::ACT_ERASE, 1'b0, 255, 0, 0, 0, 0, 0));
        pending_cmds.push_back(sss_pkg::in_req_t'({3'd5, 62'h0}));
        pending_cmds.push_back(sss_pkg::in_req_t'({3'd7, 62'h3FFF_FFFF_FFFF_FFFF}));
        pending_cmds.push_back(mk(sss_pkg::ACT_RUN, 1'b0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(sss_pkg::ACT_RUN, 1'b0, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(sss_pkg::ACT_WRITE, 1'b0, 3, 1, 1, 0, 1, 1));
        repeat (3) add_tick(1'b0);
        add_tick(1'b1);
        pending_cmds.push_back(mk(sss_pkg::ACT_STOP, 1'b1, 0, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk(sss_pkg::ACT_RUN, 1'b1, 0, 0, 0, 0, 0, 0));
        repeat (3) add_tick(1'b1);
        pending_cmds.push_back(mk(sss_pkg::ACT_STOP, 1'b0, 0, 0, 0, 0, 0, 0));
        wait_idle();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(sss_pkg::CFG_FAST, settings[p][0]);
            write_reg(sss_pkg::CFG_SLOW, settings[p][1]);
            write_reg(sss_pkg::CFG_PAUSE, settings[p][2]);
            quiet = (p == 2);
            if (p == 3)
                hold_req++;
            repeat ($urandom_range(1, 2)) add_program();
            repeat (6) pending_cmds.push_back(noise());
            wait_idle();
        end
        quiet = 1'b0;
        repeat (20) @(posedge clk);
        $display("Ran %0d requests and checked %0d statuses over six register settings.",
                 n_sent, n_seen);
        $display("Predicted %0d stage dwells and %0d missing-stage faults.", n_dwells, n_faults);
        if (errors == 0 && status_q.size() == 0)
            $display("stepper_stage_sequencer_tb: PASS");
        else
            $display("stepper_stage_sequencer_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("stepper_stage_sequencer_tb: FAIL");
        $finish;
    end
endmodule
